### src/lsbw_pkg.sv
// ----------------------------------------------------------------------------
// lsbw_pkg: shared definitions for the byte/word LIFO stack
// Store geometry, request and register codes, and the pipeline record
// that travels from the access stage to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

package lsbw_pkg;

  // Size of the byte store. It must be a power of two from 256 to 65536.
  localparam int STORE_BYTES = 65536;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int BANK_DEPTH  = STORE_BYTES / 2;
  localparam int BANK_AW     = ADDR_W - 1;

  localparam int PTR_W   = 16;
  localparam int SIZE_W  = 17;
  localparam int SPAN_W  = 18;
  localparam int DATA_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int REQ_W   = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [SPAN_W-1:0] STORE_SPAN   = SPAN_W'(STORE_BYTES);
  localparam logic [DATA_W-1:0] NO_VALUE     = 16'hFFFF;
  localparam logic [SIZE_W-1:0] SIZE_DEFAULT = 17'h10000;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_PUSH         = 3'd0;
  localparam logic [REQ_W-1:0] REQ_POP          = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PEEK         = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR        = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CURSOR_START = 3'd4;
  localparam logic [REQ_W-1:0] REQ_CURSOR_NEXT  = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE  = 2'd2;

  // Everything the result register needs besides the bank read data.
  typedef struct packed {
    logic from_mem;  // read_value comes from the store
    logic word;      // two-byte element
    logic swap;      // element starts in the odd bank
    logic refused;
    logic empty;
    logic full;
    logic more;
  } acc_info_t;

endpackage

`default_nettype wire

### src/lsbw_ram.sv
// ----------------------------------------------------------------------------
// lsbw_ram: generic single-clock RAM
// One write port and one read port; the read data is registered and holds
// its value while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module lsbw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### src/lifo_stack_byte_word_top.sv
// ----------------------------------------------------------------------------
// lifo_stack_byte_word_top: LIFO stack in a byte-addressed store
// Push, pop, peek, clear and a bottom-to-top cursor over a configurable
// region, with one or two bytes per element.
// ----------------------------------------------------------------------------
// The block takes one request per clock while in_stall is low. The
// accepting cycle updates the pointers and flags and addresses the store;
// the registered read data of the store then passes into the result
// register once that is free. The store is split into an even-byte and
// an odd-byte bank, so a two-byte element at any address is written or read
// in a single access. Configuration writes are taken at any time, but must
// only be issued while no request is in flight; a clear request applies a
// new region to the stack. The store is not initialized; reading an element
// that was never pushed returns an arbitrary value.
`default_nettype none

module lifo_stack_byte_word_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // request channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [lsbw_pkg::REQ_W-1:0]      in_req_type,
  input  wire logic [lsbw_pkg::DATA_W-1:0]     in_push_value,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [lsbw_pkg::DATA_W-1:0]     out_read_value,
  output logic                                 out_refused,
  output logic                                 out_now_empty,
  output logic                                 out_now_full,
  output logic                                 out_cursor_more,
  // configuration write channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [lsbw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lsbw_pkg::SIZE_W-1:0]     cfg_wdata
);

  localparam int PW = lsbw_pkg::PTR_W;
  localparam int AW = lsbw_pkg::ADDR_W;
  localparam int BW = lsbw_pkg::BANK_AW;
  localparam int YW = lsbw_pkg::BYTE_W;

  // Configuration registers.
  logic                        word_mode_r;
  logic [PW-1:0]               region_start_r;
  logic [lsbw_pkg::SIZE_W-1:0] region_size_r;

  // Stack state.
  logic [PW-1:0] top_r, top_nxt;
  logic          empty_r, empty_nxt;
  logic          full_r, full_nxt;
  logic [PW-1:0] cur_r, cur_nxt;
  logic          more_r, more_nxt;

  // Pipeline.
  logic                s1_valid_r, s1_valid_nxt;
  lsbw_pkg::acc_info_t s1_r, s1_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [lsbw_pkg::DATA_W-1:0] out_value_r, out_value_nxt;
  lsbw_pkg::acc_info_t out_info_r;

  logic in_acc;
  logic s1_adv;

  // Store access.
  logic [PW-1:0] acc_addr;
  logic [AW-1:0] slot;
  logic [BW-1:0] even_idx, odd_idx;
  logic          mem_wr, mem_rd;
  logic          even_we, odd_we;
  logic [YW-1:0] even_wd, odd_wd;
  logic [YW-1:0] even_q, odd_q;

  // Region arithmetic.
  logic [PW-1:0]               elem_bytes;
  logic [PW-1:0]               full_limit;
  logic [lsbw_pkg::SPAN_W-1:0] region_span;
  logic [PW-1:0]               push_addr;

  assign cfg_ready = 1'b1;

  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);

  assign elem_bytes = word_mode_r ? PW'(2) : PW'(1);
  assign full_limit = region_start_r
                    + (word_mode_r ? {region_size_r[PW-2:0], 1'b0} : region_size_r[PW-1:0])
                    - elem_bytes;
  assign region_span = lsbw_pkg::SPAN_W'(region_start_r)
                     + (word_mode_r ? lsbw_pkg::SPAN_W'({region_size_r, 1'b0})
                                    : lsbw_pkg::SPAN_W'(region_size_r));
  assign push_addr = empty_r ? top_r : top_r + elem_bytes;

  // Request decode and state update.
  always_comb begin
    top_nxt  = top_r;
    empty_nxt = empty_r;
    full_nxt = full_r;
    cur_nxt  = cur_r;
    more_nxt = more_r;
    acc_addr = top_r;
    mem_wr   = 1'b0;
    mem_rd   = 1'b0;
    s1_nxt   = '0;
    if (in_acc) begin
      case (in_req_type)
        lsbw_pkg::REQ_PUSH: begin
          if (full_r) begin
            s1_nxt.refused = 1'b1;
          end else begin
            top_nxt   = push_addr;
            acc_addr  = push_addr;
            mem_wr    = 1'b1;
            empty_nxt = 1'b0;
            full_nxt  = (push_addr == full_limit);
          end
        end
        lsbw_pkg::REQ_POP: begin
          if (!empty_r) begin
            mem_rd = 1'b1;
            if (top_r != region_start_r) begin
              top_nxt = top_r - elem_bytes;
            end else begin
              empty_nxt = 1'b1;
            end
            full_nxt = 1'b0;
          end
        end
        lsbw_pkg::REQ_PEEK: begin
          mem_rd = !empty_r;
        end
        lsbw_pkg::REQ_CLEAR: begin
          empty_nxt = 1'b1;
          if (region_span <= lsbw_pkg::STORE_SPAN) begin
            top_nxt  = region_start_r;
            full_nxt = (region_size_r == '0);
          end else begin
            full_nxt = 1'b1;
          end
        end
        lsbw_pkg::REQ_CURSOR_START: begin
          cur_nxt  = region_start_r;
          more_nxt = !empty_r;
        end
        lsbw_pkg::REQ_CURSOR_NEXT: begin
          acc_addr = cur_r;
          mem_rd   = 1'b1;
          if (cur_r == top_r) begin
            more_nxt = 1'b0;
          end else if (cur_r < top_r) begin
            cur_nxt = cur_r + elem_bytes;
          end
        end
        default: begin
        end
      endcase
      s1_nxt.from_mem = mem_rd;
      s1_nxt.word     = word_mode_r;
      s1_nxt.swap     = acc_addr[0];
      s1_nxt.empty    = empty_nxt;
      s1_nxt.full     = full_nxt;
      s1_nxt.more     = more_nxt;
    end
  end

  // A word at an odd byte address spans the odd bank at its own row and
  // the even bank at the next row.
  always_comb begin
    slot     = acc_addr[AW-1:0];
    even_idx = slot[AW-1:1] + BW'(slot[0]);
    odd_idx  = slot[AW-1:1];
    even_we  = mem_wr && (word_mode_r || !slot[0]);
    odd_we   = mem_wr && (word_mode_r || slot[0]);
    if (word_mode_r) begin
      even_wd = slot[0] ? in_push_value[YW-1:0] : in_push_value[2*YW-1:YW];
      odd_wd  = slot[0] ? in_push_value[2*YW-1:YW] : in_push_value[YW-1:0];
    end else begin
      even_wd = in_push_value[YW-1:0];
      odd_wd  = in_push_value[YW-1:0];
    end
  end

  lsbw_ram #(
    .WIDTH (YW),
    .DEPTH (lsbw_pkg::BANK_DEPTH)
  ) u_even_bank (
    .clk     (clk),
    .wr_en   (even_we),
    .wr_addr (even_idx),
    .wr_data (even_wd),
    .rd_en   (mem_rd),
    .rd_addr (even_idx),
    .rd_data (even_q)
  );

  lsbw_ram #(
    .WIDTH (YW),
    .DEPTH (lsbw_pkg::BANK_DEPTH)
  ) u_odd_bank (
    .clk     (clk),
    .wr_en   (odd_we),
    .wr_addr (odd_idx),
    .wr_data (odd_wd),
    .rd_en   (mem_rd),
    .rd_addr (odd_idx),
    .rd_data (odd_q)
  );

  // Result assembly from the bank read data.
  always_comb begin
    if (!s1_r.from_mem) begin
      out_value_nxt = lsbw_pkg::NO_VALUE;
    end else if (s1_r.word) begin
      out_value_nxt = s1_r.swap ? {odd_q, even_q} : {even_q, odd_q};
    end else begin
      out_value_nxt = {{YW{1'b0}}, (s1_r.swap ? odd_q : even_q)};
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_mode_r    <= 1'b0;
      region_start_r <= '0;
      region_size_r  <= lsbw_pkg::SIZE_DEFAULT;
      top_r          <= '0;
      empty_r        <= 1'b1;
      full_r         <= 1'b0;
      cur_r          <= '0;
      more_r         <= 1'b0;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lsbw_pkg::CFG_WORD_MODE:    word_mode_r    <= cfg_wdata[0];
          lsbw_pkg::CFG_REGION_START: region_start_r <= cfg_wdata[PW-1:0];
          lsbw_pkg::CFG_REGION_SIZE:  region_size_r  <= cfg_wdata;
          default: begin
          end
        endcase
      end
      top_r       <= top_nxt;
      empty_r     <= empty_nxt;
      full_r      <= full_nxt;
      cur_r       <= cur_nxt;
      more_r      <= more_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
    if (s1_adv) begin
      out_value_r <= out_value_nxt;
      out_info_r  <= s1_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_value_r;
  assign out_refused     = out_info_r.refused;
  assign out_now_empty   = out_info_r.empty;
  assign out_now_full    = out_info_r.full;
  assign out_cursor_more = out_info_r.more;

  // A push into a full stack is refused and leaves the pointer alone.
  a_push_full_refused : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_req_type == lsbw_pkg::REQ_PUSH && full_r
    |=> s1_r.refused && $stable(top_r))
    else $error("push into full stack was not refused");

  // The request side only stalls when both pipeline stages are occupied.
  a_stall_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("request stalled with room in the pipeline");

  // A clear always leaves the stack empty.
  a_clear_empties : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_req_type == lsbw_pkg::REQ_CLEAR |=> empty_r && s1_r.empty)
    else $error("stack not empty after clear");

  // A successful pop can never leave the stack full.
  a_pop_not_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_req_type == lsbw_pkg::REQ_POP && !empty_r |=> !full_r)
    else $error("stack full after pop");

  // A cursor step at the top element ends the walk.
  a_cursor_end : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_req_type == lsbw_pkg::REQ_CURSOR_NEXT && cur_r == top_r
    |=> !more_r && s1_r.from_mem)
    else $error("cursor walk did not end at the top element");

endmodule

`default_nettype wire

### tb/lifo_stack_byte_word_check.sv
// ----------------------------------------------------------------------------
// lifo_stack_byte_word_check: result checker for the byte/word LIFO stack
// Watches the request, result and register channels, keeps its own copy of
// the stack state and store, and compares every result word in order.
// ----------------------------------------------------------------------------
module lifo_stack_byte_word_check
  import lsbw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [REQ_W-1:0]     in_req_type,
  input  logic [DATA_W-1:0]    in_push_value,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [DATA_W-1:0]    out_read_value,
  input  logic                 out_refused,
  input  logic                 out_now_empty,
  input  logic                 out_now_full,
  input  logic                 out_cursor_more,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_wdata,
  output int unsigned          mismatch_count,
  output int unsigned          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic              refused;
    logic              now_empty;
    logic              now_full;
    logic              cursor_more;
  } stack_result_t;

  // Register copies.
  logic              wmode;
  logic [PTR_W-1:0]  base_addr;
  logic [SIZE_W-1:0] capacity;

  // Stack state copies.
  logic [BYTE_W-1:0] stack_bytes [0:STORE_BYTES-1];
  logic [PTR_W-1:0]  top_ptr;
  logic              is_empty;
  logic              is_full;
  logic [PTR_W-1:0]  walk_ptr;
  logic              walk_more;

  stack_result_t pending_results [$];

  initial begin
    mismatch_count = 0;
    outstanding    = 0;
  end

  function automatic int unsigned slot_of(logic [PTR_W-1:0] addr);
    return addr % STORE_BYTES;
  endfunction

  // Word mode keeps the high byte at the lower address.
  function automatic logic [DATA_W-1:0] element_at(logic [PTR_W-1:0] addr);
    logic [PTR_W-1:0] next_addr;
    next_addr = addr + 16'd1;
    if (wmode) begin
      return {stack_bytes[slot_of(addr)], stack_bytes[slot_of(next_addr)]};
    end
    return {8'h00, stack_bytes[slot_of(addr)]};
  endfunction

  task automatic next_stack_result(input logic [REQ_W-1:0] req,
                                   input logic [DATA_W-1:0] value,
                                   output stack_result_t res);
    logic [PTR_W-1:0]  elem_step;
    logic [SPAN_W-1:0] region_end;
    logic [PTR_W-1:0]  next_addr;
    elem_step  = wmode ? 16'd2 : 16'd1;
    region_end = {2'b00, base_addr} +
                 (wmode ? {capacity, 1'b0} : {1'b0, capacity});
    res.read_value = NO_VALUE;
    res.refused    = 1'b0;
    case (req)
      REQ_PUSH: begin
        if (is_full) begin
          res.refused = 1'b1;
        end else begin
          // The first element goes where the pointer already stands.
          if (!is_empty) top_ptr = top_ptr + elem_step;
          next_addr = top_ptr + 16'd1;
          if (wmode) begin
            stack_bytes[slot_of(top_ptr)]   = value[15:8];
            stack_bytes[slot_of(next_addr)] = value[7:0];
          end else begin
            stack_bytes[slot_of(top_ptr)] = value[7:0];
          end
          is_empty = 1'b0;
          is_full  = top_ptr == PTR_W'(region_end[PTR_W-1:0] - elem_step);
        end
      end
      REQ_POP: begin
        if (!is_empty) begin
          res.read_value = element_at(top_ptr);
          if (top_ptr != base_addr) top_ptr = top_ptr - elem_step;
          else is_empty = 1'b1;
          is_full = 1'b0;
        end
      end
      REQ_PEEK: begin
        if (!is_empty) res.read_value = element_at(top_ptr);
      end
      REQ_CLEAR: begin
        is_empty = 1'b1;
        if (region_end <= STORE_SPAN) begin
          top_ptr = base_addr;
          is_full = capacity == '0;
        end else begin
          // A region that does not fit keeps the pointer.
          is_full = 1'b1;
        end
      end
      REQ_CURSOR_START: begin
        walk_ptr  = base_addr;
        walk_more = !is_empty;
      end
      REQ_CURSOR_NEXT: begin
        res.read_value = element_at(walk_ptr);
        if (walk_ptr == top_ptr) walk_more = 1'b0;
        else if (walk_ptr < top_ptr) walk_ptr = walk_ptr + elem_step;
      end
      default: begin
      end
    endcase
    res.now_empty   = is_empty;
    res.now_full    = is_full;
    res.cursor_more = walk_more;
  endtask

  always @(posedge clk) begin : watch_channels
    stack_result_t want;
    stack_result_t got;
    if (!rst_n) begin
      wmode     = 1'b0;
      base_addr = '0;
      capacity  = SIZE_DEFAULT;
      top_ptr   = '0;
      is_empty  = 1'b1;
      is_full   = 1'b0;
      walk_ptr  = '0;
      walk_more = 1'b0;
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WORD_MODE:    wmode = cfg_wdata[0];
          CFG_REGION_START: base_addr = cfg_wdata[PTR_W-1:0];
          CFG_REGION_SIZE:  capacity = cfg_wdata;
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) begin
        next_stack_result(in_req_type, in_push_value, want);
        pending_results.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = {out_read_value, out_refused, out_now_empty, out_now_full, out_cursor_more};
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: unexpected result word: value %h refused %b empty %b full %b more %b",
                     $realtime, got.read_value, got.refused, got.now_empty, got.now_full,
                     got.cursor_more);
          end
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: result mismatch: expected value %h refused %b empty %b full %b more %b",
                       $realtime, want.read_value, want.refused, want.now_empty, want.now_full,
                       want.cursor_more);
              $display("%0t:                  got      value %h refused %b empty %b full %b more %b",
                       $realtime, got.read_value, got.refused, got.now_empty, got.now_full,
                       got.cursor_more);
            end
          end
        end
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

### tb/lifo_stack_byte_word_top_test.sv
// ----------------------------------------------------------------------------
// lifo_stack_byte_word_top_test: testbench for the byte/word LIFO stack
// Fills the bytes on both sides of address zero, runs a short directed
// sequence, then random request sequences over many region settings under
// four idling patterns.
// ----------------------------------------------------------------------------
module lifo_stack_byte_word_top_test;
  import lsbw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Codes with no defined request and the unused register slot.
  localparam logic [REQ_W-1:0]     REQ_UNUSED_6 = 3'd6;
  localparam logic [REQ_W-1:0]     REQ_UNUSED_7 = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;

  localparam int PHASE_ITEMS = 310;
  localparam int FILL_BYTES  = 256;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [REQ_W-1:0]     in_req_type = '0;
  logic [DATA_W-1:0]    in_push_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [DATA_W-1:0]    out_read_value;
  logic                 out_refused;
  logic                 out_now_empty;
  logic                 out_now_full;
  logic                 out_cursor_more;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SIZE_W-1:0]    cfg_wdata = '0;

  int unsigned mismatch_count;
  int unsigned outstanding;
  int          send_idle_pct = 0;
  int          stall_pct = 0;

  lifo_stack_byte_word_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_push_value   (in_push_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_value  (out_read_value),
    .out_refused     (out_refused),
    .out_now_empty   (out_now_empty),
    .out_now_full    (out_now_full),
    .out_cursor_more (out_cursor_more),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  lifo_stack_byte_word_check result_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_push_value   (in_push_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_value  (out_read_value),
    .out_refused     (out_refused),
    .out_now_empty   (out_now_empty),
    .out_now_full    (out_now_full),
    .out_cursor_more (out_cursor_more),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .outstanding     (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Leaves valid high after acceptance so back-to-back words need no gap.
  task automatic send_item(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] value);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_push_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stops the request channel and waits until every result word is back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Unused upper bits of the narrow registers carry random junk.
  task automatic configure(input logic mode, input logic [PTR_W-1:0] start,
                           input logic [SIZE_W-1:0] size);
    write_reg(CFG_WORD_MODE, {16'($urandom), mode});
    write_reg(CFG_REGION_START, {1'($urandom), start});
    write_reg(CFG_REGION_SIZE, size);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [REQ_W-1:0] pick_request(int push_pct);
    int r;
    r = $urandom_range(99);
    if (r < push_pct) return REQ_PUSH;
    r = $urandom_range(99);
    if (r < 45) return REQ_POP;
    if (r < 60) return REQ_PEEK;
    if (r < 66) return REQ_CLEAR;
    if (r < 74) return REQ_CURSOR_START;
    if (r < 96) return REQ_CURSOR_NEXT;
    if (r < 98) return REQ_UNUSED_6;
    return REQ_UNUSED_7;
  endfunction

  // The first settings are the corner regions; later ones are random regions
  // that start close to address zero, so that with a clear at the start of
  // every setting all pointers stay inside the bytes written by the fill.
  task automatic new_setting(input int seg);
    logic              mode;
    logic [PTR_W-1:0]  start;
    logic [SIZE_W-1:0] size;
    logic [CFG_IDX_W-1:0] idx;
    mode = 1'($urandom);
    case ($urandom_range(2))
      0: start = '0;
      default: start = 16'($urandom_range(64));
    endcase
    case ($urandom_range(9))
      0: size = '0;
      1: size = SIZE_DEFAULT;
      2: size = 17'($urandom_range(65536));
      3: size = 17'd1;
      default: size = 17'($urandom_range(40, 2));
    endcase
    case (seg)
      0: begin mode = 1'b1; start = 16'hFFFE; size = 17'd1; end
      1: begin mode = 1'b0; start = 16'hFFFF; size = 17'd1; end
      2: begin mode = 1'b1; start = 16'hFFFF; size = 17'd1; end
      3: begin mode = 1'b0; start = 16'h0000; size = 17'd0; end
      4: begin mode = 1'b0; start = 16'h0000; size = SIZE_DEFAULT; end
      5: begin mode = 1'b1; start = 16'h0000; size = SIZE_DEFAULT; end
      6: begin mode = 1'b1; start = 16'h0064; size = 17'd0; end
      7: begin mode = 1'b0; start = 16'hFFFF; size = SIZE_DEFAULT; end
      default: begin
      end
    endcase
    if (seg >= 8 && $urandom_range(99) < 15) begin
      // Write a single register slot and keep the others from the last setting.
      idx = 2'($urandom_range(3));
      case (idx)
        CFG_WORD_MODE:    write_reg(idx, {16'($urandom), mode});
        CFG_REGION_START: write_reg(idx, {1'($urandom), start});
        CFG_REGION_SIZE:  write_reg(idx, size);
        default:          write_reg(CFG_SPARE, 17'($urandom));
      endcase
      cfg_valid <= 1'b0;
    end else begin
      configure(mode, start, size);
    end
    send_item(REQ_CLEAR, 16'($urandom));
  endtask

  initial begin : stimulus
    int segment;
    int seg_len;
    int push_pct;
    int sent_in_phase;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Requests on the state right after reset; only byte zero is ever read.
    send_item(REQ_POP, 16'h0000);
    send_item(REQ_PEEK, 16'hFFFF);
    send_item(REQ_CURSOR_START, 16'h0000);
    send_item(REQ_UNUSED_6, 16'hFFFF);
    send_item(REQ_PUSH, 16'hA5C3);
    send_item(REQ_PEEK, 16'h0000);
    send_item(REQ_CURSOR_NEXT, 16'h0000);
    send_item(REQ_POP, 16'h0000);
    send_item(REQ_UNUSED_7, 16'h0000);
    drain();

    // Write the bytes on both sides of address zero; all later pointers
    // stay within them, so each read finds a byte that was written.
    configure(1'b1, 16'h0000, 17'(FILL_BYTES / 2));
    send_item(REQ_CLEAR, 16'h0000);
    for (int k = 0; k < FILL_BYTES / 2; k++) send_item(REQ_PUSH, 16'($urandom));
    drain();
    configure(1'b1, 16'(65536 - FILL_BYTES), 17'(FILL_BYTES / 2));
    send_item(REQ_CLEAR, 16'h0000);
    for (int k = 0; k < FILL_BYTES / 2; k++) send_item(REQ_PUSH, 16'($urandom));
    drain();

    // Three-element byte stack: fill, refuse, walk, empty out.
    configure(1'b0, 16'h0000, 17'd3);
    send_item(REQ_CLEAR, 16'h0000);
    send_item(REQ_PUSH, 16'hFFFF);
    send_item(REQ_PUSH, 16'h0000);
    send_item(REQ_PUSH, 16'($urandom));
    send_item(REQ_PUSH, 16'h1234);
    send_item(REQ_PEEK, 16'h0000);
    send_item(REQ_CURSOR_START, 16'h0000);
    repeat (4) send_item(REQ_CURSOR_NEXT, 16'h0000);
    repeat (4) send_item(REQ_POP, 16'h0000);
    send_item(REQ_PEEK, 16'h0000);
    send_item(REQ_CURSOR_NEXT, 16'h0000);
    send_item(REQ_UNUSED_6, 16'hFFFF);
    send_item(REQ_UNUSED_7, 16'hFFFF);
    drain();

    segment = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 55; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 55; end
        default: begin send_idle_pct = 34; stall_pct = 34; end
      endcase
      sent_in_phase = 0;
      while (sent_in_phase < PHASE_ITEMS) begin
        new_setting(segment);
        seg_len  = $urandom_range(60, 15);
        push_pct = $urandom_range(70, 20);
        for (int k = 0; k < seg_len; k++) send_item(pick_request(push_pct), 16'($urandom));
        sent_in_phase += seg_len;
        drain();
        segment++;
      end
    end

    stall_pct = 0;
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #(5_000_000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
